### rtl/core/cht_pkg.sv
// Shared constants and types of the colour histogram table.
package cht_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned COLOUR_W    = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned USED_W      = $clog2(TABLE_DEPTH + 1);

  // Control broadcast to every cell of the table.
  typedef struct packed {
    logic cap_match;
    logic inc;
    logic shift;
  } cht_cell_ctl_t;

endpackage

### rtl/core/cht_cell.sv
// One table cell: a stored colour, its count and the compare against the lookup key.
module cht_cell
  import cht_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cht_cell_ctl_t          ctl_i,
  input  logic                   load_i,
  input  logic                   occupied_i,
  input  logic [COLOUR_W-1:0]    key_i,
  input  logic [COLOUR_W-1:0]    nb_colour_i,
  input  logic [COUNT_WIDTH-1:0] nb_count_i,
  output logic [COLOUR_W-1:0]    colour_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic                   match_o
);

  logic [COLOUR_W-1:0]    colour_q, colour_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   match_q, match_d;

  always_comb begin
    match_d = match_q;
    if (ctl_i.cap_match) begin
      match_d = occupied_i && (colour_q == key_i);
    end
  end

  always_comb begin
    colour_d = colour_q;
    count_d  = count_q;
    if (ctl_i.shift) begin
      colour_d = nb_colour_i;
      count_d  = nb_count_i;
    end else if (load_i) begin
      colour_d = key_i;
      count_d  = COUNT_WIDTH'(1);
    end else if (ctl_i.inc && match_q && (count_q != {COUNT_WIDTH{1'b1}})) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    colour_q <= colour_d;
    count_q  <= count_d;
  end

  assign colour_o = colour_q;
  assign count_o  = count_q;
  assign match_o  = match_q;

endmodule

### rtl/core/colour_histogram_table.sv
// Top level of the colour histogram table: a row of cells with a lookup and dump sequencer.
// A count transaction passes these steps before the next one can be accepted: capture,
// compare in every cell at once, update of the hit or appended cell, and the result register
// write, which waits while the receiver holds the result register. A dump rotates all
// TABLE_DEPTH cells through cell 0, one step a cycle except while a stored entry waits for
// the result register; an empty-table dump gives one result with no entry. Reset clears the
// entry count and the sequencer; stored colours and counts are read only below the count.
module colour_histogram_table
  import cht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] colour
  input  logic [0:0]  s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // [5:0] entry_index, [37:6] entry_colour,
                                     // [69:38] entry_count, [71:70] zero
  output logic [2:0]  m_axis_tuser,  // [0] is_new, [1] table_full, [2] entry_valid
  output logic        m_axis_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_DUMP = 3'd4;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_NEW   = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_DEPTH);
  localparam logic [USED_W-1:0] K_LAST   = USED_W'(TABLE_DEPTH - 1);

  logic [2:0]          state_q, state_d;
  logic [1:0]          kind_q, kind_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  logic [COLOUR_W-1:0] key_q, key_d;

  logic                m_valid_q, m_valid_d;
  logic [5:0]          o_idx_q, o_idx_d;
  logic [31:0]         o_colour_q, o_colour_d;
  logic [31:0]         o_count_q, o_count_d;
  logic                o_new_q, o_new_d;
  logic                o_full_q, o_full_d;
  logic                o_valid_q, o_valid_d;
  logic                o_last_q, o_last_d;

  cht_cell_ctl_t           ctl;
  logic [TABLE_DEPTH-1:0]  load_vec;
  logic [TABLE_DEPTH-1:0]  occ_vec;
  logic [TABLE_DEPTH-1:0]  match_vec;
  logic [COLOUR_W-1:0]     cell_colour [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]  cell_count  [TABLE_DEPTH];

  logic                    accept;
  logic                    out_free;
  logic                    any_hit;
  logic [IDX_W-1:0]        hit_idx;
  logic [COUNT_WIDTH-1:0]  hit_count;
  logic [63:0]             hit_count_wide;
  logic [63:0]             head_count_wide;
  logic                    dump_emit;
  logic                    load_new;

  // The row of cells. During a dump every cell takes its right neighbor's entry and the
  // last cell takes cell 0's, so a full rotation leaves the table as it was.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned NB = (i + 1) % TABLE_DEPTH;

    assign occ_vec[i]  = USED_W'(i) < used_q;
    assign load_vec[i] = load_new && (USED_W'(i) == used_q);

    cht_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .load_i     (load_vec[i]),
      .occupied_i (occ_vec[i]),
      .key_i      (key_q),
      .nb_colour_i(cell_colour[NB]),
      .nb_count_i (cell_count[NB]),
      .colour_o   (cell_colour[i]),
      .count_o    (cell_count[i]),
      .match_o    (match_vec[i])
    );
  end

  // Stored colours are distinct, so at most one cell matches and an AND-OR select is enough.
  always_comb begin
    hit_idx   = '0;
    hit_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_vec[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_count = hit_count | cell_count[i];
      end
    end
  end

  assign any_hit         = |match_vec;
  assign hit_count_wide  = 64'(hit_count);
  assign head_count_wide = 64'(cell_count[0]);

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign dump_emit = USED_W'(k_q) < used_q;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    used_d     = used_q;
    k_d        = k_q;
    res_idx_d  = res_idx_q;
    key_d      = key_q;
    ctl        = '0;
    load_new   = 1'b0;

    m_valid_d  = m_valid_q && !m_axis_tready;
    o_idx_d    = o_idx_q;
    o_colour_d = o_colour_q;
    o_count_d  = o_count_q;
    o_new_d    = o_new_q;
    o_full_d   = o_full_q;
    o_valid_d  = o_valid_q;
    o_last_d   = o_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = s_axis_tdata;
          k_d   = '0;
          if (s_axis_tuser[0]) begin
            if (used_q == '0) begin
              kind_d  = KIND_EMPTY;
              state_d = ST_RES;
            end else begin
              state_d = ST_DUMP;
            end
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        ctl.cap_match = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_RES;
        if (any_hit) begin
          ctl.inc = 1'b1;
          kind_d  = KIND_HIT;
        end else if (used_q == USED_MAX) begin
          kind_d = KIND_FULL;
        end else begin
          load_new  = 1'b1;
          res_idx_d = IDX_W'(used_q);
          used_d    = used_q + USED_W'(1);
          kind_d    = KIND_NEW;
        end
      end
      ST_RES: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          o_idx_d    = '0;
          o_colour_d = '0;
          o_count_d  = '0;
          o_new_d    = 1'b0;
          o_full_d   = 1'b0;
          o_valid_d  = 1'b0;
          o_last_d   = 1'b1;
          case (kind_q)
            KIND_HIT: begin
              o_idx_d    = 6'(hit_idx);
              o_colour_d = key_q;
              o_count_d  = hit_count_wide[31:0];
              o_valid_d  = 1'b1;
            end
            KIND_NEW: begin
              o_idx_d    = 6'(res_idx_q);
              o_colour_d = key_q;
              o_count_d  = 32'd1;
              o_new_d    = 1'b1;
              o_valid_d  = 1'b1;
            end
            KIND_FULL: begin
              o_full_d = 1'b1;
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // Steps past the stored entries rotate without emitting a result.
        if (!dump_emit || out_free) begin
          ctl.shift = 1'b1;
          if (dump_emit) begin
            m_valid_d  = 1'b1;
            o_idx_d    = 6'(k_q);
            o_colour_d = cell_colour[0];
            o_count_d  = head_count_wide[31:0];
            o_new_d    = 1'b0;
            o_full_d   = 1'b0;
            o_valid_d  = 1'b1;
            o_last_d   = (USED_W'(k_q) + USED_W'(1)) == used_q;
          end
          if (USED_W'(k_q) == K_LAST) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= KIND_HIT;
      used_q    <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      used_q    <= used_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q  <= res_idx_d;
    key_q      <= key_d;
    o_idx_q    <= o_idx_d;
    o_colour_q <= o_colour_d;
    o_count_q  <= o_count_d;
    o_new_q    <= o_new_d;
    o_full_q   <= o_full_d;
    o_valid_q  <= o_valid_d;
    o_last_q   <= o_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, o_count_q, o_colour_q, o_idx_q};
  assign m_axis_tuser  = {o_valid_q, o_full_q, o_new_q};
  assign m_axis_tlast  = o_last_q;

  // Duplicate colours in the table would show up as more than one matching cell.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one cell matched the lookup key");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_MAX)
    else $error("entry count beyond table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + USED_W'(1)))
    else $error("entry count changed by other than one");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (used_q == USED_MAX))
    else $error("drop flagged while the table has room");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("new transaction taken while one is in progress");

endmodule

### tb/colour_histogram_table_tb.sv
// Self-checking testbench for the colour histogram table: streamed pixels against a predictor.
module colour_histogram_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cht_pkg::*;

  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_DUMP  = 1'b1;

  localparam int IDLE_PCT     = 6;
  localparam int RANDOM_ITEMS = 205;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 120;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct {
    logic                action;
    logic [COLOUR_W-1:0] colour;
  } pixel_t;

  typedef struct {
    logic [IDX_W-1:0]    index;
    logic [COLOUR_W-1:0] colour;
    logic [31:0]         count;
    logic                is_new;
    logic                full;
    logic                valid;
    logic                last;
  } entry_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [31:0] colour
  logic [0:0]  s_axis_tuser  = '0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [5:0] index, [37:6] colour, [69:38] count, [71:70] zero
  logic [2:0]  m_axis_tuser;        // [0] is_new, [1] table_full, [2] entry_valid
  logic        m_axis_tlast;

  colour_histogram_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predicted table contents.
  logic [COLOUR_W-1:0]    colour_tbl [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] count_tbl  [TABLE_DEPTH];
  int                     entries_used = 0;

  pixel_t              pending_q [$];
  entry_report_t       report_q  [$];
  logic [COLOUR_W-1:0] palette   [$];

  int  items_total  = 0;
  int  items_taken  = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  quiet_cycles = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  in_fire      = 1'b0;
  bit  out_fire     = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Updates the predicted table for one pixel transaction and queues the entries it reports.
  task automatic histogram_step(input pixel_t px);
    entry_report_t rep;
    int            hit;
    hit = -1;
    rep = '{index: '0, colour: '0, count: '0, is_new: 1'b0, full: 1'b0, valid: 1'b0,
            last: 1'b1};
    if (px.action == ACT_DUMP) begin
      if (entries_used == 0) report_q.push_back(rep);
      for (int i = 0; i < entries_used; i++) begin
        rep.index  = IDX_W'(i);
        rep.colour = colour_tbl[i];
        rep.count  = 32'(count_tbl[i]);
        rep.valid  = 1'b1;
        rep.last   = (i == entries_used - 1);
        report_q.push_back(rep);
      end
    end else begin
      for (int i = 0; i < entries_used; i++) begin
        if (hit < 0 && colour_tbl[i] == px.colour) hit = i;
      end
      if (hit >= 0) begin
        if (count_tbl[hit] != COUNT_MAX) count_tbl[hit] = count_tbl[hit] + 1'b1;
        rep.index  = IDX_W'(hit);
        rep.colour = px.colour;
        rep.count  = 32'(count_tbl[hit]);
        rep.valid  = 1'b1;
      end else if (entries_used >= TABLE_DEPTH) begin
        rep.full = 1'b1;
      end else begin
        colour_tbl[entries_used] = px.colour;
        count_tbl[entries_used]  = COUNT_WIDTH'(1);
        rep.index  = IDX_W'(entries_used);
        rep.colour = px.colour;
        rep.count  = 32'd1;
        rep.is_new = 1'b1;
        rep.valid  = 1'b1;
        entries_used++;
      end
      report_q.push_back(rep);
    end
  endtask

  // The palette keeps distinct counted colours in arrival order, which is table order too.
  task automatic queue_pixel(input logic action, input logic [COLOUR_W-1:0] colour);
    pixel_t px;
    bit     known;
    px.action = action;
    px.colour = colour;
    pending_q.push_back(px);
    known = 1'b0;
    foreach (palette[i]) if (palette[i] == colour) known = 1'b1;
    if (action == ACT_COUNT && !known) palette.push_back(colour);
  endtask

  // Driver: offers the next pixel once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_q.size() != 0 &&
            !((items_taken < 100 || items_taken >= 160) && $urandom_range(99) < IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_q[0].action;
          s_axis_tdata  <= pending_q[0].colour;
          pending_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold that backs the block up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !((results_seen < 250 || results_seen >= 400) &&
                           $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Monitor: checks each result transaction and feeds accepted pixels to the predictor.
  always @(posedge clk_i) begin
    entry_report_t want;
    pixel_t        px;
    if (rst_ni) begin
      in_fire  = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (out_fire) begin
        if (report_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
        end else begin
          want = report_q.pop_front();
          check_field("entry_index", m_axis_tdata[IDX_W-1:0], want.index);
          check_field("entry_colour", m_axis_tdata[IDX_W +: COLOUR_W], want.colour);
          check_field("entry_count", m_axis_tdata[IDX_W+COLOUR_W +: 32], want.count);
          check_field("padding", m_axis_tdata[71:IDX_W+COLOUR_W+32], '0);
          check_field("is_new", m_axis_tuser[0], want.is_new);
          check_field("table_full", m_axis_tuser[1], want.full);
          check_field("entry_valid", m_axis_tuser[2], want.valid);
          check_field("last", m_axis_tlast, want.last);
        end
        results_seen++;
      end
      if (in_fire) begin
        px.action = s_axis_tuser[0];
        px.colour = s_axis_tdata;
        histogram_step(px);
        items_taken++;
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int r;
    // Directed part: empty dump, extreme colours, hits, new entries and dumps in between.
    queue_pixel(ACT_DUMP,  32'hFFFF_FFFF);
    queue_pixel(ACT_COUNT, 32'h0000_0000);
    queue_pixel(ACT_COUNT, 32'h0000_0000);
    queue_pixel(ACT_COUNT, 32'hFFFF_FFFF);
    queue_pixel(ACT_COUNT, 32'hFFFF_FFFF);
    queue_pixel(ACT_COUNT, 32'hFFFF_FFFF);
    queue_pixel(ACT_COUNT, 32'h8000_0000);
    queue_pixel(ACT_COUNT, 32'h0000_0001);
    queue_pixel(ACT_DUMP,  32'h0000_0000);
    queue_pixel(ACT_COUNT, 32'hAAAA_AAAA);
    queue_pixel(ACT_COUNT, 32'h5555_5555);
    queue_pixel(ACT_COUNT, 32'h0000_0000);
    queue_pixel(ACT_COUNT, 32'h1234_5678);
    queue_pixel(ACT_COUNT, 32'h8000_0000);
    queue_pixel(ACT_DUMP,  32'h5A5A_A5A5);
    // Random part: mostly repeats of known colours so that hits dominate.
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 6) queue_pixel(ACT_DUMP, $urandom);
      else if (r < 60) queue_pixel(ACT_COUNT, palette[$urandom_range(palette.size() - 1)]);
      else queue_pixel(ACT_COUNT, $urandom);
    end
    // Make sure the table overflows, then drop, hit and dump a full table.
    while (palette.size() <= TABLE_DEPTH) queue_pixel(ACT_COUNT, $urandom);
    queue_pixel(ACT_DUMP,  32'h0000_0000);
    queue_pixel(ACT_COUNT, palette[TABLE_DEPTH]);
    queue_pixel(ACT_COUNT, palette[0]);
    queue_pixel(ACT_COUNT, palette[TABLE_DEPTH-1]);
    queue_pixel(ACT_DUMP,  32'hFFFF_FFFF);
    items_total = pending_q.size();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != items_total) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
